// ----- rtl/y2r_pkg.sv -----
// Shared types, register codes and coefficient table for the YCbCr to RGB converter.
// No dependencies.
`default_nettype none
package y2r_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_SELECT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROUNDING_MODE = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_FORMAT = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTE_ORDER    = 4'd3;

  // Matrix codes
  localparam logic [1:0] MATRIX_STD    = 2'd0;
  localparam logic [1:0] MATRIX_BT601  = 2'd1;
  localparam logic [1:0] MATRIX_BT709  = 2'd2;

  localparam logic ROUND_JOINT = 1'b0;
  localparam logic ROUND_TERM  = 1'b1;

  localparam logic FMT_RGB565 = 1'b0;
  localparam logic FMT_RGB24  = 1'b1;

  localparam logic ORDER_LITTLE = 1'b0;
  localparam logic ORDER_BIG    = 1'b1;

  localparam logic [1:0] COUNT_RGB565 = 2'd2;
  localparam logic [1:0] COUNT_RGB24  = 2'd3;

  // 2.8 coefficients, all positive, below 1024
  typedef struct packed {
    logic [9:0] rv;
    logic [9:0] gu;
    logic [9:0] gv;
    logic [9:0] bu;
  } coef_t;

  // Matrix-stage configuration
  typedef struct packed {
    logic [1:0] matrix_select;
    logic       rounding_mode;
  } y2r_cfg_t;

  // Channel value before clamping
  typedef logic signed [11:0] chan_t;

  function automatic coef_t coef_lookup(input logic [1:0] sel);
    coef_t c;
    unique case (sel)
      MATRIX_BT601: c = '{rv: 10'd292, gu: 10'd101, gv: 10'd149, bu: 10'd520};
      MATRIX_BT709: c = '{rv: 10'd328, gu: 10'd55,  gv: 10'd97,  bu: 10'd545};
      default:      c = '{rv: 10'd351, gu: 10'd86,  gv: 10'd179, bu: 10'd444};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/y2r_pixel_if.sv -----
// Input stream interface: one YCbCr pixel per word.
// No dependencies.
`default_nettype none
interface y2r_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;

  modport source (output valid, luma, chroma_blue, chroma_red, input ready);
  modport sink   (input valid, luma, chroma_blue, chroma_red, output ready);
endinterface
`default_nettype wire

// ----- rtl/y2r_rgb_if.sv -----
// Output stream interface: packed RGB bytes per word.
// No dependencies.
`default_nettype none
interface y2r_rgb_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_bytes;
  logic [1:0]  byte_count;

  modport source (output valid, pixel_bytes, byte_count, input ready);
  modport sink   (input valid, pixel_bytes, byte_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/y2r_matrix.sv -----
// Three-stage colour matrix: chroma offset and coefficient fetch, products, sums with floor.
// Depends on y2r_pkg.
`default_nettype none
module y2r_matrix (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire logic             in_valid,
  input  wire logic [7:0]       luma,
  input  wire logic [7:0]       chroma_blue,
  input  wire logic [7:0]       chroma_red,
  input  wire y2r_pkg::y2r_cfg_t cfg,
  output logic                  out_valid,
  output y2r_pkg::chan_t        r_sum,
  output y2r_pkg::chan_t        g_sum,
  output y2r_pkg::chan_t        b_sum
);
  import y2r_pkg::*;

  // stage 1
  logic              s1_valid;
  logic [7:0]        s1_y;
  logic signed [8:0] s1_u;
  logic signed [8:0] s1_v;
  coef_t             s1_coef;
  logic              s1_mode;

  // stage 2
  logic               s2_valid;
  logic [7:0]         s2_y;
  logic signed [19:0] s2_pr;
  logic signed [19:0] s2_pgu;
  logic signed [19:0] s2_pgv;
  logic signed [19:0] s2_pb;
  logic               s2_mode;

  chan_t r_next;
  chan_t g_next;
  chan_t b_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_y    <= luma;
      s1_u    <= signed'({1'b0, chroma_blue}) - 9'sd128;
      s1_v    <= signed'({1'b0, chroma_red}) - 9'sd128;
      s1_coef <= coef_lookup(cfg.matrix_select);
      s1_mode <= cfg.rounding_mode;

      s2_y    <= s1_y;
      s2_mode <= s1_mode;
      s2_pr   <= signed'({1'b0, s1_coef.rv}) * s1_v;
      s2_pgu  <= signed'({1'b0, s1_coef.gu}) * s1_u;
      s2_pgv  <= signed'({1'b0, s1_coef.gv}) * s1_v;
      s2_pb   <= signed'({1'b0, s1_coef.bu}) * s1_u;

      r_sum   <= r_next;
      g_sum   <= g_next;
      b_sum   <= b_next;
    end
  end

  // Arithmetic shift right floors; joint mode shifts the whole sum once
  always_comb begin
    logic signed [19:0] y_hi;
    logic signed [19:0] rj;
    logic signed [19:0] gj;
    logic signed [19:0] bj;
    logic signed [19:0] pr_f;
    logic signed [19:0] pgu_f;
    logic signed [19:0] pgv_f;
    logic signed [19:0] pb_f;
    chan_t              y_c;
    y_hi  = signed'({4'b0000, s2_y, 8'h00});
    rj    = (y_hi + s2_pr) >>> 8;
    gj    = (y_hi - s2_pgu - s2_pgv) >>> 8;
    bj    = (y_hi + s2_pb) >>> 8;
    pr_f  = s2_pr >>> 8;
    pgu_f = s2_pgu >>> 8;
    pgv_f = s2_pgv >>> 8;
    pb_f  = s2_pb >>> 8;
    y_c   = signed'({4'b0000, s2_y});
    if (s2_mode == ROUND_TERM) begin
      r_next = y_c + pr_f[11:0];
      g_next = y_c - pgu_f[11:0] - pgv_f[11:0];
      b_next = y_c + pb_f[11:0];
    end else begin
      r_next = rj[11:0];
      g_next = gj[11:0];
      b_next = bj[11:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/yuv_to_rgb_pixel_converter.sv -----
// Top level of the YCbCr to RGB pixel converter: configuration registers, matrix
// pipeline, clamp and pack stage. Depends on y2r_pkg, y2r_pixel_if, y2r_rgb_if, y2r_matrix.
//
// Converts one YCbCr pixel (8-bit Y, Cb, Cr; chroma offset by 128) per word into
// RGB565 (two bytes) or RGB24 (three bytes), first byte in pixel_bytes[7:0].
// Throughput is one pixel per clock while the output is not stalled; an accepted
// pixel reaches the output register through the four register stages (chroma offset
// and coefficient fetch, multipliers, sums with floor, clamp and pack), the first of
// which loads at the accepting edge. The pipeline advances as a
// whole whenever the output register is empty or being taken, so a stall on the
// output holds every stage. Matrix codes: 0 normal, 1 BT.601, 2 BT.709, 3 behaves
// as normal. Rounding: 0 floors the joint sum, 1 floors each chroma term. Registers
// are written through cfg_we/cfg_index/cfg_data and must only change while the
// pipeline is empty; writes to unknown indexes are ignored.
`default_nettype none
module yuv_to_rgb_pixel_converter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [y2r_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [y2r_pkg::CFG_DATA_W-1:0]  cfg_data,
  y2r_pixel_if.sink                            pix_in,
  y2r_rgb_if.source                            pix_out
);
  import y2r_pkg::*;

  logic [1:0] matrix_select;
  logic       rounding_mode;
  logic       output_format;
  logic       byte_order;

  y2r_cfg_t   mat_cfg;
  logic       adv;
  logic       mat_valid;
  chan_t      r_sum;
  chan_t      g_sum;
  chan_t      b_sum;

  logic [7:0]  r_c;
  logic [7:0]  g_c;
  logic [7:0]  b_c;
  logic [23:0] bytes_next;
  logic [1:0]  count_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_select <= MATRIX_STD;
      rounding_mode <= ROUND_JOINT;
      output_format <= FMT_RGB565;
      byte_order    <= ORDER_LITTLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MATRIX_SELECT: matrix_select <= cfg_data;
        REG_ROUNDING_MODE: rounding_mode <= cfg_data[0];
        REG_OUTPUT_FORMAT: output_format <= cfg_data[0];
        REG_BYTE_ORDER:    byte_order    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves when the output register is free or being emptied
  assign adv          = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = adv;

  assign mat_cfg = '{matrix_select: matrix_select, rounding_mode: rounding_mode};

  y2r_matrix u_matrix (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (pix_in.valid),
    .luma        (pix_in.luma),
    .chroma_blue (pix_in.chroma_blue),
    .chroma_red  (pix_in.chroma_red),
    .cfg         (mat_cfg),
    .out_valid   (mat_valid),
    .r_sum       (r_sum),
    .g_sum       (g_sum),
    .b_sum       (b_sum)
  );

  // Saturate each channel to a byte
  function automatic logic [7:0] clamp_byte(input chan_t x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'h00;
    end else if (x > 12'sd255) begin
      res = 8'hFF;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  always_comb begin
    logic [7:0] hi;
    logic [7:0] lo;
    r_c = clamp_byte(r_sum);
    g_c = clamp_byte(g_sum);
    b_c = clamp_byte(b_sum);
    hi  = {r_c[7:3], g_c[7:5]};
    lo  = {g_c[4:2], b_c[7:3]};
    if (output_format == FMT_RGB24) begin
      count_next = COUNT_RGB24;
      if (byte_order == ORDER_BIG) begin
        bytes_next = {r_c, g_c, b_c};
      end else begin
        bytes_next = {b_c, g_c, r_c};
      end
    end else begin
      count_next = COUNT_RGB565;
      if (byte_order == ORDER_BIG) begin
        bytes_next = {8'h00, lo, hi};
      end else begin
        bytes_next = {8'h00, hi, lo};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (adv) begin
      pix_out.valid <= mat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_out.pixel_bytes <= bytes_next;
      pix_out.byte_count  <= count_next;
    end
  end

  // Checks
  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> (pix_out.byte_count == COUNT_RGB565 ||
                       pix_out.byte_count == COUNT_RGB24))
    else $error("byte_count out of range");

  a_565_top_zero: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && pix_out.byte_count == COUNT_RGB565) |->
      (pix_out.pixel_bytes[23:16] == 8'h00))
    else $error("RGB565 word has a third byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pix_out.valid)
    else $error("output valid straight after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (pix_out.valid && !pix_out.ready) |=> $stable(mat_valid))
    else $error("matrix pipeline moved during stall");

endmodule
`default_nettype wire
